@@ hdl/bsu_pkg.sv @@
// ----------------------------------------------------------------------------
// bsu_pkg
// Shared types and constants for the bytecode stack unit.
// ----------------------------------------------------------------------------
package bsu_pkg;

   localparam int DEPTH   = 64;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;

   typedef enum logic [2:0] {
      CMD_PUSH      = 3'd0,
      CMD_PRINT_ALL = 3'd1,
      CMD_PRINT_TOP = 3'd2,
      CMD_POP       = 3'd3,
      CMD_SWAP      = 3'd4
   } command_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TOP_EMPTY  = 3'd1,
      ST_POP_EMPTY  = 3'd2,
      ST_SWAP_SHORT = 3'd3,
      ST_FULL       = 3'd4,
      ST_HALTED     = 3'd5
   } status_type;

   // Operation broadcast to every cell of the chain.
   typedef enum logic [2:0] {
      SH_HOLD,
      SH_PUSH,
      SH_POP,
      SH_ROTATE,
      SH_SWAP
   } shift_type;

   // Where a cell sits relative to the top of the stack.
   typedef struct packed {
      logic is_top;
      logic is_second;
      logic is_last;
   } cell_pos_type;

endpackage

@@ hdl/bytecode_stack_unit_top.sv @@
// ----------------------------------------------------------------------------
// bytecode_stack_unit_top
// Bounded stack of signed 32-bit values executing interpreter opcodes.
// ----------------------------------------------------------------------------
// The stack lives in a chain of DEPTH cells with the top entry always in
// cell 0. For push, pop, print top and swap, a request is accepted whenever
// the unit is idle and the response register is free; its single response
// appears in the next cycle. Print all on a stack of N entries gives N
// responses, top first, one per cycle while the consumer keeps up; it rotates
// the occupied part of the chain by one cell per response and leaves the
// stack as it was. A failing command (print top, pop or swap on a too-short
// stack, push onto a full stack) reports its status and halts the unit;
// after that every request answers with status halted until reset.
// Responses without a printed entry carry data_value 0 and data_valid 0.
// No clearing pass after reset is needed.
// ----------------------------------------------------------------------------
module bytecode_stack_unit_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_command,
   input  logic signed [bsu_pkg::VALUE_W-1:0]  req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [bsu_pkg::VALUE_W-1:0]  rsp_data_value,
   output logic                                rsp_data_valid,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_last_result
);

   typedef enum logic {
      IDLE,
      PRINT
   } state_type;

   state_type                           state_ff, state_in;
   logic [bsu_pkg::COUNT_W-1:0]         count_ff, count_in;   // entries held
   logic [bsu_pkg::COUNT_W-1:0]         remain_ff, remain_in; // print all left
   logic                                halted_ff, halted_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [bsu_pkg::VALUE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                                rsp_dvalid_ff, rsp_dvalid_in;
   bsu_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic                                rsp_last_ff, rsp_last_in;

   bsu_pkg::shift_type                  shift;
   logic signed [bsu_pkg::VALUE_W-1:0]  cell_value [bsu_pkg::DEPTH];

   logic rsp_free;
   logic accept;

   // response register can take a new response this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != IDLE) || !rsp_free;
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Cell chain: cell 0 is the top, cell i+1 lies below cell i.
   // ------------------------------------------------------------------
   genvar gi;
   generate
      for (gi = 0; gi < bsu_pkg::DEPTH; gi++) begin : g_cell
         bsu_pkg::cell_pos_type               pos;
         logic signed [bsu_pkg::VALUE_W-1:0]  prev_value;
         logic signed [bsu_pkg::VALUE_W-1:0]  next_value;

         assign pos.is_top    = (gi == 0);
         assign pos.is_second = (gi == 1);
         assign pos.is_last   = (count_ff == bsu_pkg::COUNT_W'(gi + 1));

         if (gi == 0) begin : g_first
            assign prev_value = req_push_value;
         end else begin : g_inner
            assign prev_value = cell_value[gi-1];
         end

         if (gi == bsu_pkg::DEPTH - 1) begin : g_bottom
            assign next_value = '0;
         end else begin : g_above
            assign next_value = cell_value[gi+1];
         end

         bsu_cell u_cell (
            .clock      (clock),
            .shift      (shift),
            .pos        (pos),
            .prev_value (prev_value),
            .next_value (next_value),
            .wrap_value (cell_value[0]),
            .value      (cell_value[gi])
         );
      end
   endgenerate

   // ------------------------------------------------------------------
   // Command decode and print-all walk
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      halted_in     = halted_ff;
      shift         = bsu_pkg::SH_HOLD;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_dvalid_in = rsp_dvalid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_dvalid_in = 1'b0;
               rsp_status_in = bsu_pkg::ST_OK;
               rsp_last_in   = 1'b1;
               if (halted_ff) begin
                  rsp_status_in = bsu_pkg::ST_HALTED;
               end else begin
                  case (req_command)
                     bsu_pkg::CMD_PUSH: begin
                        if (count_ff == bsu_pkg::COUNT_W'(bsu_pkg::DEPTH)) begin
                           rsp_status_in = bsu_pkg::ST_FULL;
                           halted_in     = 1'b1;
                        end else begin
                           shift    = bsu_pkg::SH_PUSH;
                           count_in = count_ff + 1'b1;
                        end
                     end
                     bsu_pkg::CMD_PRINT_ALL: begin
                        if (count_ff != '0) begin
                           rsp_data_in   = cell_value[0];
                           rsp_dvalid_in = 1'b1;
                           rsp_last_in   = (count_ff == bsu_pkg::COUNT_W'(1));
                           shift         = bsu_pkg::SH_ROTATE;
                           remain_in     = count_ff - 1'b1;
                           if (count_ff != bsu_pkg::COUNT_W'(1)) begin
                              state_in = PRINT;
                           end
                        end
                     end
                     bsu_pkg::CMD_PRINT_TOP: begin
                        if (count_ff == '0) begin
                           rsp_status_in = bsu_pkg::ST_TOP_EMPTY;
                           halted_in     = 1'b1;
                        end else begin
                           rsp_data_in   = cell_value[0];
                           rsp_dvalid_in = 1'b1;
                        end
                     end
                     bsu_pkg::CMD_POP: begin
                        if (count_ff == '0) begin
                           rsp_status_in = bsu_pkg::ST_POP_EMPTY;
                           halted_in     = 1'b1;
                        end else begin
                           shift    = bsu_pkg::SH_POP;
                           count_in = count_ff - 1'b1;
                        end
                     end
                     bsu_pkg::CMD_SWAP: begin
                        if (count_ff < bsu_pkg::COUNT_W'(2)) begin
                           rsp_status_in = bsu_pkg::ST_SWAP_SHORT;
                           halted_in     = 1'b1;
                        end else begin
                           shift = bsu_pkg::SH_SWAP;
                        end
                     end
                     default: begin
                        // unused codes: no operation, status ok
                        rsp_status_in = bsu_pkg::ST_OK;
                     end
                  endcase
               end
            end
         end
         PRINT: begin
            // one entry per free response slot; rotation restores order
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = cell_value[0];
               rsp_dvalid_in = 1'b1;
               rsp_status_in = bsu_pkg::ST_OK;
               rsp_last_in   = (remain_ff == bsu_pkg::COUNT_W'(1));
               shift         = bsu_pkg::SH_ROTATE;
               remain_in     = remain_ff - 1'b1;
               if (remain_ff == bsu_pkg::COUNT_W'(1)) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_dvalid_ff <= rsp_dvalid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_value  = rsp_data_ff;
   assign rsp_data_valid  = rsp_dvalid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

@@ hdl/bsu_cell.sv @@
// ----------------------------------------------------------------------------
// bsu_cell
// One stack entry. Takes its value from a neighbor on push, pop, rotate, swap.
// ----------------------------------------------------------------------------
module bsu_cell (
   input  logic                              clock,
   input  bsu_pkg::shift_type                shift,
   input  bsu_pkg::cell_pos_type             pos,
   input  logic signed [bsu_pkg::VALUE_W-1:0] prev_value,
   input  logic signed [bsu_pkg::VALUE_W-1:0] next_value,
   input  logic signed [bsu_pkg::VALUE_W-1:0] wrap_value,
   output logic signed [bsu_pkg::VALUE_W-1:0] value
);

   logic signed [bsu_pkg::VALUE_W-1:0] value_ff;
   logic signed [bsu_pkg::VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (shift)
         bsu_pkg::SH_PUSH: begin
            value_in = prev_value;
         end
         bsu_pkg::SH_POP: begin
            value_in = next_value;
         end
         bsu_pkg::SH_ROTATE: begin
            // last occupied entry wraps around to the old top
            value_in = pos.is_last ? wrap_value : next_value;
         end
         bsu_pkg::SH_SWAP: begin
            if (pos.is_top) begin
               value_in = next_value;
            end else if (pos.is_second) begin
               value_in = prev_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
